>>> rtl/cdt_pkg.sv
package cdt_pkg;

  // event codes
  localparam logic [3:0] CMD_TICK   = 4'd0;
  localparam logic [3:0] CMD_CLICK  = 4'd1;
  localparam logic [3:0] CMD_HOLD   = 4'd2;
  localparam logic [3:0] CMD_DOUBLE = 4'd3;
  localparam logic [3:0] CMD_RESET  = 4'd4;
  localparam logic [3:0] CMD_UP     = 4'd5;
  localparam logic [3:0] CMD_DOWN   = 4'd6;
  localparam logic [3:0] CMD_LEFT   = 4'd7;
  localparam logic [3:0] CMD_RIGHT  = 4'd8;
  localparam logic [3:0] CMD_LOAD   = 4'd9;

  // display modes
  localparam logic [1:0] MODE_STOP      = 2'd0;
  localparam logic [1:0] MODE_START     = 2'd1;
  localparam logic [1:0] MODE_SET_CLOCK = 2'd2;
  localparam logic [1:0] MODE_SET_TIMER = 2'd3;

  // timer edit cursor positions
  localparam logic [1:0] CUR_SECONDS = 2'd0;
  localparam logic [1:0] CUR_MINUTES = 2'd1;
  localparam logic [1:0] CUR_HOURS   = 2'd2;

  // limits and defaults
  localparam logic [15:0] LIMIT_SECONDS   = 16'd43200;
  localparam logic [15:0] DEFAULT_SECONDS = 16'd600;
  localparam logic [31:0] ERASED_LOAD     = 32'hFFFF_FFFF;
  localparam logic [4:0]  LAST_HOUR       = 5'd23;
  localparam logic [5:0]  LAST_MINUTE     = 6'd59;

  typedef struct packed {
    logic [3:0]  cmd;
    logic [31:0] load_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] remaining_seconds;
    logic        running;
    logic        alarm_pulse;
    logic        alarm_clear;
    logic        save_preset;
    logic [1:0]  timer_cursor;
    logic        clock_cursor;
    logic [4:0]  clock_hour;
    logic [5:0]  clock_minute;
  } out_item_t;

  // seconds per step of the timer edit cursor
  function automatic logic [11:0] step_size(input logic [1:0] cursor);
    logic [11:0] s;
    case (cursor)
      CUR_SECONDS: s = 12'd1;
      CUR_MINUTES: s = 12'd60;
      default:     s = 12'd3600;
    endcase
    return s;
  endfunction

endpackage

>>> rtl/countdown_timer_controller_core.sv
// channel | signals                          | accepted when
// --------+----------------------------------+---------------------------
// events  | cmd_valid, cmd_stall, cmd_item   | cmd_valid && !cmd_stall
// results | res_valid, res_stall, res_item   | res_valid && !res_stall
// config  | max_seconds_we, max_seconds_data | max_seconds_we
//
// One item per cycle sustained while the result side does not stall; an accepted item
// shows its result once it moves from the input register to the result register.
// The state update and result forming sit in one short layer of logic.
// rst (synchronous) empties both registers and returns all state to its
// defaults. A stall on the result side holds the result; the input
// register keeps one item, and cmd_stall rises only while both are full.
module countdown_timer_controller_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  cdt_pkg::in_item_t  cmd_item,
  output logic               res_valid,
  input  logic               res_stall,
  output cdt_pkg::out_item_t res_item,
  input  logic               max_seconds_we,
  input  logic [15:0]        max_seconds_data
);

  // input register
  logic              in_full;
  cdt_pkg::in_item_t in_reg;

  // controller state
  logic [15:0] max_seconds;
  logic [15:0] remaining, remaining_next;
  logic [15:0] restart_value, restart_value_next;
  logic        run_flag, run_flag_next;
  logic        service_flag, service_flag_next;
  logic        clock_set_flag, clock_set_flag_next;
  logic [1:0]  mode_reg, mode_reg_next;
  logic [1:0]  digit_cursor, digit_cursor_next;
  logic        field_cursor, field_cursor_next;
  logic [4:0]  hour_reg, hour_reg_next;
  logic [5:0]  minute_reg, minute_reg_next;
  logic        alarm, cleared, save;

  logic [11:0] inc;
  logic [16:0] up_sum;
  logic [15:0] load_sat;
  logic        advance;

  // handshake: result register frees when empty or taken
  assign advance   = in_full && (!res_valid || !res_stall);
  assign cmd_stall = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!cmd_stall) begin
      in_full <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!cmd_stall && cmd_valid) begin
      in_reg <= cmd_item;
    end
  end

  // edit arithmetic and load saturation
  assign inc    = cdt_pkg::step_size(digit_cursor);
  assign up_sum = {1'b0, remaining} + {5'd0, inc};

  always_comb begin
    if (in_reg.load_value == cdt_pkg::ERASED_LOAD) begin
      load_sat = cdt_pkg::DEFAULT_SECONDS;
    end else if (in_reg.load_value > {16'd0, cdt_pkg::LIMIT_SECONDS}) begin
      load_sat = cdt_pkg::LIMIT_SECONDS;
    end else begin
      load_sat = in_reg.load_value[15:0];
    end
  end

  // event decode and next state
  always_comb begin
    remaining_next      = remaining;
    restart_value_next  = restart_value;
    run_flag_next       = run_flag;
    service_flag_next   = service_flag;
    clock_set_flag_next = clock_set_flag;
    mode_reg_next       = mode_reg;
    digit_cursor_next   = digit_cursor;
    field_cursor_next   = field_cursor;
    hour_reg_next       = hour_reg;
    minute_reg_next     = minute_reg;
    alarm               = 1'b0;
    cleared             = 1'b0;
    save                = 1'b0;
    unique case (in_reg.cmd)
      cdt_pkg::CMD_TICK: begin
        if (run_flag) begin
          if (remaining != 16'd0) begin
            remaining_next = remaining - 16'd1;
          end else begin
            run_flag_next  = 1'b0;
            alarm          = 1'b1;
            remaining_next = restart_value;
          end
        end
      end
      cdt_pkg::CMD_CLICK: begin
        if (!run_flag && !service_flag && !clock_set_flag) begin
          restart_value_next = remaining;
          run_flag_next      = 1'b1;
          mode_reg_next      = cdt_pkg::MODE_START;
        end else begin
          run_flag_next = 1'b0;
          if (service_flag) begin
            service_flag_next  = 1'b0;
            restart_value_next = remaining;
            save               = 1'b1;
          end else begin
            clock_set_flag_next = 1'b0;
          end
          mode_reg_next = cdt_pkg::MODE_STOP;
        end
      end
      cdt_pkg::CMD_HOLD: begin
        if (!run_flag) begin
          clock_set_flag_next = 1'b1;
          mode_reg_next       = cdt_pkg::MODE_SET_CLOCK;
        end
      end
      cdt_pkg::CMD_DOUBLE: begin
        if (!run_flag) begin
          restart_value_next = remaining;
          service_flag_next  = 1'b1;
          mode_reg_next      = cdt_pkg::MODE_SET_TIMER;
        end
      end
      cdt_pkg::CMD_RESET: begin
        if (!run_flag) begin
          remaining_next = restart_value;
          cleared        = 1'b1;
        end
      end
      cdt_pkg::CMD_UP: begin
        if (mode_reg == cdt_pkg::MODE_SET_TIMER) begin
          if (up_sum <= {1'b0, max_seconds}) begin
            remaining_next = up_sum[15:0];
          end
        end else if (mode_reg == cdt_pkg::MODE_SET_CLOCK) begin
          if (field_cursor) begin
            hour_reg_next = (hour_reg == cdt_pkg::LAST_HOUR) ? 5'd0 : hour_reg + 5'd1;
          end else begin
            minute_reg_next = (minute_reg == cdt_pkg::LAST_MINUTE) ? 6'd0
                                                                    : minute_reg + 6'd1;
          end
        end
      end
      cdt_pkg::CMD_DOWN: begin
        if (mode_reg == cdt_pkg::MODE_SET_TIMER) begin
          if ({4'd0, inc} <= remaining) begin
            remaining_next = remaining - {4'd0, inc};
          end
        end else if (mode_reg == cdt_pkg::MODE_SET_CLOCK) begin
          if (field_cursor) begin
            if (hour_reg != 5'd0) begin
              hour_reg_next = hour_reg - 5'd1;
            end
          end else if (minute_reg != 6'd0) begin
            minute_reg_next = minute_reg - 6'd1;
          end
        end
      end
      cdt_pkg::CMD_LEFT: begin
        if (mode_reg == cdt_pkg::MODE_SET_TIMER) begin
          digit_cursor_next = (digit_cursor == cdt_pkg::CUR_HOURS) ? cdt_pkg::CUR_SECONDS
                                                                    : digit_cursor + 2'd1;
        end else if (mode_reg == cdt_pkg::MODE_SET_CLOCK) begin
          field_cursor_next = ~field_cursor;
        end
      end
      cdt_pkg::CMD_RIGHT: begin
        if (mode_reg == cdt_pkg::MODE_SET_TIMER) begin
          digit_cursor_next = (digit_cursor == cdt_pkg::CUR_SECONDS) ? cdt_pkg::CUR_HOURS
                                                                      : digit_cursor - 2'd1;
        end else if (mode_reg == cdt_pkg::MODE_SET_CLOCK) begin
          field_cursor_next = ~field_cursor;
        end
      end
      cdt_pkg::CMD_LOAD: begin
        remaining_next     = load_sat;
        restart_value_next = load_sat;
      end
      default: begin
      end
    endcase
  end

  // limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_seconds <= cdt_pkg::LIMIT_SECONDS;
    end else if (max_seconds_we) begin
      max_seconds <= max_seconds_data;
    end
  end

  // state update, one item per advance
  always_ff @(posedge clk) begin
    if (rst) begin
      remaining      <= cdt_pkg::DEFAULT_SECONDS;
      restart_value  <= cdt_pkg::DEFAULT_SECONDS;
      run_flag       <= 1'b0;
      service_flag   <= 1'b0;
      clock_set_flag <= 1'b0;
      mode_reg       <= cdt_pkg::MODE_STOP;
      digit_cursor   <= cdt_pkg::CUR_SECONDS;
      field_cursor   <= 1'b0;
      hour_reg       <= 5'd0;
      minute_reg     <= 6'd0;
    end else if (advance) begin
      remaining      <= remaining_next;
      restart_value  <= restart_value_next;
      run_flag       <= run_flag_next;
      service_flag   <= service_flag_next;
      clock_set_flag <= clock_set_flag_next;
      mode_reg       <= mode_reg_next;
      digit_cursor   <= digit_cursor_next;
      field_cursor   <= field_cursor_next;
      hour_reg       <= hour_reg_next;
      minute_reg     <= minute_reg_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (!res_valid || !res_stall) begin
      res_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_item.mode              <= mode_reg_next;
      res_item.remaining_seconds <= remaining_next;
      res_item.running           <= run_flag_next;
      res_item.alarm_pulse       <= alarm;
      res_item.alarm_clear       <= cleared;
      res_item.save_preset       <= save;
      res_item.timer_cursor      <= digit_cursor_next;
      res_item.clock_cursor      <= field_cursor_next;
      res_item.clock_hour        <= hour_reg_next;
      res_item.clock_minute      <= minute_reg_next;
    end
  end

endmodule

>>> rtl/cdt_checker.sv
module cdt_checker (
  input logic               clk,
  input logic               rst,
  input logic               res_valid,
  input logic               res_stall,
  input cdt_pkg::out_item_t res_item
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_item))
    else $error("stalled result changed");

  // expiry always stops the countdown
  a_alarm_stops: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.alarm_pulse |-> !res_item.running)
    else $error("alarm while running");

  // saving the preset leaves the block stopped
  a_save_stop: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.save_preset |->
      !res_item.running && res_item.mode == cdt_pkg::MODE_STOP)
    else $error("save outside stop");

  // clock and cursor stay in range
  a_ranges: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_item.clock_hour <= cdt_pkg::LAST_HOUR &&
      res_item.clock_minute <= cdt_pkg::LAST_MINUTE && res_item.timer_cursor != 2'd3)
    else $error("field out of range");

endmodule

bind countdown_timer_controller_core cdt_checker u_cdt_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res_item  (res_item)
);

>>> test/countdown_timer_controller_core_test.sv
module countdown_timer_controller_core_test;

  // command codes the block leaves unused
  localparam logic [3:0] CMD_SPARE_LO = 4'd10;
  localparam logic [3:0] CMD_SPARE_HI = 4'd15;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 190;

  // predicts the status word for every accepted event and checks results
  class timer_status_board;
    logic [15:0]        limit_secs;
    logic [15:0]        remaining;
    logic [15:0]        restart;
    bit                 run;
    bit                 service;
    bit                 clock_set;
    logic [1:0]         mode;
    logic [1:0]         digit;
    bit                 field;
    logic [4:0]         hour;
    logic [5:0]         minute;
    cdt_pkg::out_item_t expected_status[$];
    int                 failures;
    int                 checked;
    int                 expiries;
    int                 saves;
    int                 silenced;

    function new();
      limit_secs = cdt_pkg::LIMIT_SECONDS;
      remaining = cdt_pkg::DEFAULT_SECONDS;
      restart = cdt_pkg::DEFAULT_SECONDS;
      run = 1'b0;
      service = 1'b0;
      clock_set = 1'b0;
      mode = cdt_pkg::MODE_STOP;
      digit = cdt_pkg::CUR_SECONDS;
      field = 1'b0;
      hour = '0;
      minute = '0;
      failures = 0;
      checked = 0;
      expiries = 0;
      saves = 0;
      silenced = 0;
    endfunction

    function void set_limit(logic [15:0] v);
      limit_secs = v;
    endfunction

    // next state and status word for one event
    function void apply_event(cdt_pkg::in_item_t it);
      cdt_pkg::out_item_t r;
      int unsigned        inc;
      logic [31:0]        ld;
      r = '0;
      inc = (digit == cdt_pkg::CUR_SECONDS) ? 1 : (digit == cdt_pkg::CUR_MINUTES) ? 60 : 3600;
      case (it.cmd) inside
        cdt_pkg::CMD_TICK: begin
          if (run) begin
            if (remaining != 16'd0) begin
              remaining = remaining - 16'd1;
            end else begin
              run = 1'b0;
              r.alarm_pulse = 1'b1;
              remaining = restart;
            end
          end
        end
        cdt_pkg::CMD_CLICK: begin
          if (!run && !service && !clock_set) begin
            restart = remaining;
            run = 1'b1;
            mode = cdt_pkg::MODE_START;
          end else begin
            run = 1'b0;
            if (service) begin
              service = 1'b0;
              restart = remaining;
              r.save_preset = 1'b1;
            end else if (clock_set) begin
              clock_set = 1'b0;
            end
            mode = cdt_pkg::MODE_STOP;
          end
        end
        cdt_pkg::CMD_HOLD: begin
          if (!run) begin
            clock_set = 1'b1;
            mode = cdt_pkg::MODE_SET_CLOCK;
          end
        end
        cdt_pkg::CMD_DOUBLE: begin
          if (!run) begin
            restart = remaining;
            service = 1'b1;
            mode = cdt_pkg::MODE_SET_TIMER;
          end
        end
        cdt_pkg::CMD_RESET: begin
          if (!run) begin
            remaining = restart;
            r.alarm_clear = 1'b1;
          end
        end
        cdt_pkg::CMD_UP, cdt_pkg::CMD_DOWN, cdt_pkg::CMD_LEFT, cdt_pkg::CMD_RIGHT: begin
          if (mode == cdt_pkg::MODE_SET_TIMER) begin
            // timer digits: step depends on the cursor, up bounded by the limit
            case (it.cmd)
              cdt_pkg::CMD_UP: begin
                if (int'(remaining) + inc <= int'(limit_secs))
                  remaining = remaining + 16'(inc);
              end
              cdt_pkg::CMD_DOWN: begin
                if (inc <= remaining) remaining = remaining - 16'(inc);
              end
              cdt_pkg::CMD_LEFT: begin
                digit = (digit == cdt_pkg::CUR_HOURS) ? cdt_pkg::CUR_SECONDS : digit + 2'd1;
              end
              default: begin
                digit = (digit == cdt_pkg::CUR_SECONDS) ? cdt_pkg::CUR_HOURS : digit - 2'd1;
              end
            endcase
          end else if (mode == cdt_pkg::MODE_SET_CLOCK) begin
            // clock fields: up wraps, down stops at zero
            case (it.cmd)
              cdt_pkg::CMD_UP: begin
                if (field) hour = (hour == cdt_pkg::LAST_HOUR) ? 5'd0 : hour + 5'd1;
                else minute = (minute == cdt_pkg::LAST_MINUTE) ? 6'd0 : minute + 6'd1;
              end
              cdt_pkg::CMD_DOWN: begin
                if (field) begin
                  if (hour != 5'd0) hour = hour - 5'd1;
                end else begin
                  if (minute != 6'd0) minute = minute - 6'd1;
                end
              end
              default: field = ~field;
            endcase
          end
        end
        cdt_pkg::CMD_LOAD: begin
          ld = it.load_value;
          if (ld == cdt_pkg::ERASED_LOAD) ld = 32'(cdt_pkg::DEFAULT_SECONDS);
          else if (ld > 32'(cdt_pkg::LIMIT_SECONDS)) ld = 32'(cdt_pkg::LIMIT_SECONDS);
          remaining = ld[15:0];
          restart = ld[15:0];
        end
        default: ;
      endcase
      r.mode = mode;
      r.remaining_seconds = remaining;
      r.running = run;
      r.timer_cursor = digit;
      r.clock_cursor = field;
      r.clock_hour = hour;
      r.clock_minute = minute;
      expiries += r.alarm_pulse;
      saves += r.save_preset;
      silenced += r.alarm_clear;
      expected_status.push_back(r);
    endfunction

    function string show(cdt_pkg::out_item_t s);
      return $sformatf("mode=%0d rem=%0d run=%0b alm=%0b clr=%0b sav=%0b tc=%0d cc=%0b %0d:%0d",
                       s.mode, s.remaining_seconds, s.running, s.alarm_pulse, s.alarm_clear,
                       s.save_preset, s.timer_cursor, s.clock_cursor, s.clock_hour,
                       s.clock_minute);
    endfunction

    // compare one result with the oldest prediction
    function void check_status(cdt_pkg::out_item_t got);
      cdt_pkg::out_item_t want;
      if (expected_status.size() == 0) begin
        failures++;
        if (failures <= 10) $display("unexpected result: %s", show(got));
        return;
      end
      want = expected_status.pop_front();
      checked++;
      if (got.mode !== want.mode || got.remaining_seconds !== want.remaining_seconds ||
          got.running !== want.running || got.alarm_pulse !== want.alarm_pulse ||
          got.alarm_clear !== want.alarm_clear || got.save_preset !== want.save_preset ||
          got.timer_cursor !== want.timer_cursor || got.clock_cursor !== want.clock_cursor ||
          got.clock_hour !== want.clock_hour || got.clock_minute !== want.clock_minute) begin
        failures++;
        if (failures <= 10) begin
          $display("mismatch on result %0d", checked);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

  logic               clk;
  logic               rst = 1'b1;
  logic               cmd_valid = 1'b0;
  logic               cmd_stall;
  cdt_pkg::in_item_t  cmd_item = '0;
  logic               res_valid;
  logic               res_stall = 1'b0;
  cdt_pkg::out_item_t res_item;
  logic               max_seconds_we = 1'b0;
  logic [15:0]        max_seconds_data = '0;

  timer_status_board board = new();
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          sent = 0;
  int          cycles = 0;
  int          target;
  int          n;
  int          sel;
  int          r;
  logic [3:0]  c;
  logic [15:0] limits [PHASES];

  countdown_timer_controller_core uut (
    .clk              (clk),
    .rst              (rst),
    .cmd_valid        (cmd_valid),
    .cmd_stall        (cmd_stall),
    .cmd_item         (cmd_item),
    .res_valid        (res_valid),
    .res_stall        (res_stall),
    .res_item         (res_item),
    .max_seconds_we   (max_seconds_we),
    .max_seconds_data (max_seconds_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               board.expected_status.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: random stall, check on every accepted item
  always @(negedge clk) begin
    res_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) board.check_status(res_item);
  end

  // present one event, hold it until accepted, then predict its result
  task automatic send_event(input logic [3:0] code, input logic [31:0] v);
    cdt_pkg::in_item_t it;
    it.cmd = code;
    it.load_value = v;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      cmd_valid <= 1'b0;
    end
    @(negedge clk);
    cmd_valid <= 1'b1;
    cmd_item <= it;
    do @(posedge clk); while (cmd_stall);
    board.apply_event(it);
    sent++;
  endtask

  // stop sending and let every predicted result come out
  task automatic wait_drained();
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (board.expected_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // preset values of every flavor: erased, saturating, small, medium, wide random
  function automatic logic [31:0] pick_load();
    case ($urandom_range(9)) inside
      0:       return cdt_pkg::ERASED_LOAD;
      1, 2:    return $urandom;
      3:       return 32'(cdt_pkg::LIMIT_SECONDS) + $urandom_range(0, 3);
      4, 5, 6: return $urandom_range(0, 8);
      default: return $urandom_range(9, 3700);
    endcase
  endfunction

  initial begin
    limits[0] = cdt_pkg::LIMIT_SECONDS;
    limits[1] = 16'd1;
    limits[2] = 16'hFFFF;
    limits[3] = 16'($urandom_range(2, 43199));
    limits[4] = 16'd3601;
    limits[5] = cdt_pkg::LIMIT_SECONDS;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < PHASES; phase++) begin
      // idle pattern: sender light / receiver heavy, then swapped, then none
      case (phase / 2)
        0: begin send_idle_pct = 13; stall_pct = 77; end
        1: begin send_idle_pct = 77; stall_pct = 13; end
        default: begin send_idle_pct = 0; stall_pct = 0; end
      endcase

      // limit register written only while the block is idle
      wait_drained();
      @(negedge clk);
      max_seconds_we <= 1'b1;
      max_seconds_data <= limits[phase];
      @(negedge clk);
      max_seconds_we <= 1'b0;
      board.set_limit(limits[phase]);

      if (phase == 0) begin
        // directed: ignored events, load corners, expiry, both edit modes
        send_event(cdt_pkg::CMD_TICK, 32'h0);
        send_event(cdt_pkg::CMD_UP, 32'hFFFF_FFFF);
        send_event(cdt_pkg::CMD_LOAD, cdt_pkg::ERASED_LOAD);
        send_event(cdt_pkg::CMD_LOAD, 32'(cdt_pkg::LIMIT_SECONDS) + 32'd1);
        send_event(cdt_pkg::CMD_LOAD, 32'd2);
        send_event(cdt_pkg::CMD_CLICK, 32'h5555_5555);
        send_event(cdt_pkg::CMD_HOLD, 32'h0);
        send_event(cdt_pkg::CMD_DOUBLE, 32'h0);
        send_event(cdt_pkg::CMD_RESET, 32'h0);
        repeat (3) send_event(cdt_pkg::CMD_TICK, 32'hAAAA_AAAA);
        send_event(cdt_pkg::CMD_RESET, 32'h0);
        send_event(cdt_pkg::CMD_DOUBLE, 32'h0);
        send_event(cdt_pkg::CMD_UP, 32'h0);
        send_event(cdt_pkg::CMD_RIGHT, 32'h0);
        send_event(cdt_pkg::CMD_DOWN, 32'h0);
        send_event(cdt_pkg::CMD_LEFT, 32'h0);
        send_event(cdt_pkg::CMD_UP, 32'h0);
        send_event(cdt_pkg::CMD_CLICK, 32'h0);
        send_event(cdt_pkg::CMD_HOLD, 32'h0);
        send_event(cdt_pkg::CMD_DOWN, 32'h0);
        send_event(cdt_pkg::CMD_LEFT, 32'h0);
        send_event(cdt_pkg::CMD_DOWN, 32'h0);
        send_event(cdt_pkg::CMD_CLICK, 32'h0);
        send_event(CMD_SPARE_HI, 32'hFFFF_FFFF);
      end

      // random part: mostly well-formed sessions with random content
      target = sent + ITEMS_PER_PHASE;
      while (sent < target) begin
        sel = $urandom_range(99);
        if (sel < 30) begin
          // countdown run, in half the runs from a short preset so it can expire
          if ($urandom_range(1)) send_event(cdt_pkg::CMD_LOAD, $urandom_range(0, 6));
          send_event(cdt_pkg::CMD_CLICK, $urandom);
          n = $urandom_range(1, 12);
          repeat (n) begin
            if ($urandom_range(9) == 0) begin
              send_event(4'($urandom_range(cdt_pkg::CMD_HOLD, cdt_pkg::CMD_RIGHT)), $urandom);
            end else begin
              send_event(cdt_pkg::CMD_TICK, $urandom);
            end
          end
          if ($urandom_range(1)) send_event(cdt_pkg::CMD_CLICK, $urandom);
          send_event(cdt_pkg::CMD_RESET, $urandom);
        end else if (sel < 50) begin
          // timer preset editing, left by a click that saves if the edit mode was entered
          if ($urandom_range(3) == 0) send_event(cdt_pkg::CMD_LOAD, pick_load());
          send_event(cdt_pkg::CMD_DOUBLE, $urandom);
          n = $urandom_range(3, 15);
          repeat (n) begin
            send_event(4'($urandom_range(cdt_pkg::CMD_UP, cdt_pkg::CMD_RIGHT)), $urandom);
          end
          send_event(cdt_pkg::CMD_CLICK, $urandom);
        end else if (sel < 65) begin
          // clock editing, biased upward so both fields wrap
          send_event(cdt_pkg::CMD_HOLD, $urandom);
          n = $urandom_range(5, 70);
          repeat (n) begin
            r = $urandom_range(99);
            if (r < 72) c = cdt_pkg::CMD_UP;
            else if (r < 84) c = cdt_pkg::CMD_DOWN;
            else if (r < 92) c = cdt_pkg::CMD_LEFT;
            else c = cdt_pkg::CMD_RIGHT;
            send_event(c, $urandom);
          end
          send_event(cdt_pkg::CMD_CLICK, $urandom);
        end else if (sel < 80) begin
          send_event(cdt_pkg::CMD_LOAD, pick_load());
        end else begin
          // noise: any code including the unused ones
          n = $urandom_range(1, 4);
          repeat (n) begin
            if ($urandom_range(7) == 0) c = 4'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
            else c = 4'($urandom_range(cdt_pkg::CMD_TICK, cdt_pkg::CMD_LOAD));
            send_event(c, pick_load());
          end
        end
      end
    end

    wait_drained();
    $display("covered %0d events and %0d results: %0d expiries, %0d saves, %0d resets",
             sent, board.checked, board.expiries, board.saves, board.silenced);
    $display("limit register set %0d times from 1 to 65535 under three idle patterns",
             PHASES);
    if (board.failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d failures", board.failures);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/cdt_pkg.sv
rtl/countdown_timer_controller_core.sv
rtl/cdt_checker.sv
test/countdown_timer_controller_core_test.sv
